// File: design/ftm_pkg.sv
// Shared types, constants and command codes of the torque modulator.
// Used by the register file, controller, datapath and top level.
package ftm_pkg;

    localparam int ANGLE_W = 14;
    localparam int CMP_W   = 11;
    localparam int ADDR_W  = 5;

    localparam logic [CMP_W-1:0] PWM_TOP = 11'd1999;

    // sine polynomial coefficients in Q15 and sqrt(3)/2 in Q16
    localparam logic [15:0] SIN_A          = 16'd51472;
    localparam logic [15:0] SIN_B          = 16'd21024;
    localparam logic [15:0] SIN_C          = 16'd2320;
    localparam logic [16:0] HALF_SQRT3_Q16 = 17'd56756;

    // register indexes
    localparam logic [2:0] REG_RUN_MODE  = 3'd0;
    localparam logic [2:0] REG_POLE      = 3'd1;
    localparam logic [2:0] REG_REVERSE   = 3'd2;
    localparam logic [2:0] REG_ZERO_OFS  = 3'd3;
    localparam logic [2:0] REG_VLIMIT    = 3'd4;
    localparam logic [2:0] REG_SUPPLY    = 3'd5;

    // datapath operations
    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_ELEC  = 4'd1;
    localparam logic [3:0] OP_UQ    = 4'd2;
    localparam logic [3:0] OP_X2    = 4'd3;
    localparam logic [3:0] OP_T1    = 4'd4;
    localparam logic [3:0] OP_T2    = 4'd5;
    localparam logic [3:0] OP_S     = 4'd6;
    localparam logic [3:0] OP_PS    = 4'd7;
    localparam logic [3:0] OP_PC    = 4'd8;
    localparam logic [3:0] OP_KC    = 4'd9;
    localparam logic [3:0] OP_PHASE = 4'd10;
    localparam logic [3:0] OP_NUMER = 4'd11;
    localparam logic [3:0] OP_DIV   = 4'd12;

    typedef struct packed {
        logic        run_mode;
        logic [5:0]  pole_pairs;
        logic        reverse_direction;
        logic [13:0] zero_offset;
        logic [15:0] voltage_limit_mv;
        logic [15:0] supply_mv;
    } cfg_t;

    typedef struct packed {
        logic       capture;
        logic [3:0] op;
        logic       cos_sel;
        logic       load_out;
    } cmd_t;

endpackage

// File: design/foc_torque_modulator.sv
// Sinusoidal torque-mode modulator: angle in, three PWM compare counts out.
// One tick at a time: 15 multiply and phase steps, 11 quotient bits of the three-lane
//   restoring divider and one output load, which waits while the output register is full;
//   only then does the sequencer return to idle to take the next transfer.
// Reset (aresetn low, synchronous): sequencer idle, output empty, previous angle zero,
//   registers at their defaults (pole pairs 7, limit 5000 mV, supply 12000 mV).
module foc_torque_modulator (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sensor_word[15:0], torque_command[31:16]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // compare_a[10:0], compare_b[21:11], compare_c[32:22],
                                   // mech_angle[46:33], speed[60:47], elec_angle[74:61]
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [ftm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ftm_pkg::*;

    cfg_t               cfg;
    cmd_t               cmd;
    logic [CMP_W-1:0]   compare_a;
    logic [CMP_W-1:0]   compare_b;
    logic [CMP_W-1:0]   compare_c;
    logic [ANGLE_W-1:0] mech_angle;
    logic [ANGLE_W-1:0] speed;
    logic [ANGLE_W-1:0] elec_angle;

    // no wait states on the register port
    assign pready = 1'b1;

    ftm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // sequencer: takes one transfer at a time, one step per cycle; the load may wait
    ftm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // datapath: the output register lets the next tick start while a result waits
    ftm_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .cmd            (cmd),
        .sensor_word    (s_tdata[15:0]),
        .torque_command (signed'(s_tdata[31:16])),
        .compare_a      (compare_a),
        .compare_b      (compare_b),
        .compare_c      (compare_c),
        .mech_angle     (mech_angle),
        .speed          (speed),
        .elec_angle     (elec_angle)
    );

    // pack result fields, lowest first, zero fill to whole bytes
    assign m_tdata = {5'd0, elec_angle, speed, mech_angle, compare_c, compare_b, compare_a};

endmodule

// File: design/ftm_cfg.sv
// Configuration register file behind the APB-style port.
// Depends on ftm_pkg for the register indexes and the cfg_t bundle.
module ftm_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ftm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output ftm_pkg::cfg_t              cfg
);
    import ftm_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] index;
    logic       wr_en;

    assign index = paddr[4:2];
    assign wr_en = psel & penable & pwrite;
    assign cfg   = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (index)
                REG_RUN_MODE: cfg_next.run_mode          = pwdata[0];
                REG_POLE:     cfg_next.pole_pairs        = pwdata[5:0];
                REG_REVERSE:  cfg_next.reverse_direction = pwdata[0];
                REG_ZERO_OFS: cfg_next.zero_offset       = pwdata[13:0];
                REG_VLIMIT:   cfg_next.voltage_limit_mv  = pwdata[15:0];
                REG_SUPPLY:   cfg_next.supply_mv         = pwdata[15:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (index)
            REG_RUN_MODE: prdata = {31'd0, cfg_reg.run_mode};
            REG_POLE:     prdata = {26'd0, cfg_reg.pole_pairs};
            REG_REVERSE:  prdata = {31'd0, cfg_reg.reverse_direction};
            REG_ZERO_OFS: prdata = {18'd0, cfg_reg.zero_offset};
            REG_VLIMIT:   prdata = {16'd0, cfg_reg.voltage_limit_mv};
            REG_SUPPLY:   prdata = {16'd0, cfg_reg.supply_mv};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.run_mode          <= 1'b0;
            cfg_reg.pole_pairs        <= 6'd7;
            cfg_reg.reverse_direction <= 1'b0;
            cfg_reg.zero_offset       <= 14'd0;
            cfg_reg.voltage_limit_mv  <= 16'd5000;
            cfg_reg.supply_mv         <= 16'd12000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: design/ftm_ctrl.sv
// Sequencer of the modulator: steps the datapath through one tick.
// Depends on ftm_pkg for the operation codes and cmd_t.
module ftm_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output ftm_pkg::cmd_t cmd
);
    import ftm_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CALC   = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [3:0] CALC_LAST = 4'd14;
    localparam logic [3:0] DIV_LAST  = 4'd10;

    logic [1:0] state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;

    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CALC;
                    step_next   = 4'd0;
                end
            end
            ST_CALC: begin
                case (step_reg)
                    4'd0:    cmd.op = OP_ELEC;
                    4'd1:    cmd.op = OP_UQ;
                    4'd2:    cmd.op = OP_X2;
                    4'd3:    cmd.op = OP_T1;
                    4'd4:    cmd.op = OP_T2;
                    4'd5:    cmd.op = OP_S;
                    4'd6:    cmd.op = OP_X2;
                    4'd7:    cmd.op = OP_T1;
                    4'd8:    cmd.op = OP_T2;
                    4'd9:    cmd.op = OP_S;
                    4'd10:   cmd.op = OP_PS;
                    4'd11:   cmd.op = OP_PC;
                    4'd12:   cmd.op = OP_KC;
                    4'd13:   cmd.op = OP_PHASE;
                    4'd14:   cmd.op = OP_NUMER;
                    default: cmd.op = OP_NONE;
                endcase
                // second sine pass evaluates the cosine
                cmd.cos_sel = (step_reg >= 4'd6) && (step_reg <= 4'd9);
                if (step_reg == CALC_LAST) begin
                    state_next = ST_DIV;
                    step_next  = 4'd0;
                end else begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_DIV: begin
                cmd.op = OP_DIV;
                if (step_reg == DIV_LAST) begin
                    state_next = ST_FINISH;
                end else begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_capture_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> state_reg == ST_CALC)
        else $error("capture did not start a calculation");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("output overwritten before transfer");
    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> step_reg <= DIV_LAST)
        else $error("divider step out of range");
`endif

endmodule

// File: design/ftm_dp.sv
// Datapath: angle capture, shared multiplier, phase voltages, three-lane divider.
// Depends on ftm_pkg for cfg_t, cmd_t, operation codes and constants.
module ftm_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ftm_pkg::cfg_t               cfg,
    input  ftm_pkg::cmd_t               cmd,
    input  logic [15:0]                 sensor_word,
    input  logic signed [15:0]          torque_command,
    output logic [ftm_pkg::CMP_W-1:0]   compare_a,
    output logic [ftm_pkg::CMP_W-1:0]   compare_b,
    output logic [ftm_pkg::CMP_W-1:0]   compare_c,
    output logic [ftm_pkg::ANGLE_W-1:0] mech_angle,
    output logic [ftm_pkg::ANGLE_W-1:0] speed,
    output logic [ftm_pkg::ANGLE_W-1:0] elec_angle
);
    import ftm_pkg::*;

    // tick operands
    logic [ANGLE_W-1:0] mech_reg;     // also the previous angle for speed
    logic [ANGLE_W-1:0] speed_reg;
    logic signed [15:0] tq_reg;
    logic [ANGLE_W-1:0] elec_reg;
    logic signed [15:0] uq_reg;
    // sine evaluation
    logic [15:0]        x_reg;
    logic [15:0]        x2_reg;
    logic [15:0]        t_reg;
    logic signed [16:0] s_reg;
    logic signed [16:0] c_reg;
    // voltage products
    logic signed [32:0] ps_reg;
    logic signed [32:0] pc_reg;
    logic signed [49:0] kc_reg;
    // division lanes
    logic [46:0]        v_reg   [3];
    logic [57:0]        rem_reg [3];
    logic [10:0]        q_reg   [3];
    logic               sat_reg [3];
    logic               nz_reg  [3];
    logic [57:0]        d_reg;
    // output register
    logic [CMP_W-1:0]   cmp_out_reg [3];
    logic [ANGLE_W-1:0] mech_out_reg;
    logic [ANGLE_W-1:0] speed_out_reg;
    logic [ANGLE_W-1:0] elec_out_reg;

    // shared multiplier
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] mul_p;

    logic [9:0]         sin_idx;
    logic [1:0]         quad;
    logic [14:0]        x_raw;
    logic [15:0]        x_cur;
    logic [16:0]        s_mag;
    logic signed [16:0] s_val;
    logic signed [32:0] p_adj;
    logic [ANGLE_W-1:0] prod14;
    logic [ANGLE_W-1:0] dir14;

    logic signed [49:0] half_w;
    logic signed [49:0] ps_w;
    logic signed [49:0] u_w [3];
    logic [46:0]        lim_w;
    logic [46:0]        dsup_w;
    logic [46:0]        v_w  [3];
    logic [57:0]        numer_w [3];
    logic [CMP_W-1:0]   cmp_w [3];

    // sine quadrant decode; cosine is a quarter turn ahead
    assign sin_idx = elec_reg[13:4] + (cmd.cos_sel ? 10'd256 : 10'd0);
    assign quad    = sin_idx[9:8];
    assign x_raw   = {sin_idx[7:0], 7'd0};
    assign x_cur   = quad[0] ? (16'd32768 - 16'(x_raw)) : 16'(x_raw);

    always_comb begin
        case (cmd.op)
            OP_ELEC: begin
                mul_a = 33'(mech_reg);
                mul_b = 18'(cfg.pole_pairs);
            end
            OP_UQ: begin
                mul_a = 33'(tq_reg);
                mul_b = 18'(cfg.voltage_limit_mv);
            end
            OP_X2: begin
                mul_a = 33'(x_cur);
                mul_b = 18'(x_cur);
            end
            OP_T1: begin
                mul_a = 33'(SIN_C);
                mul_b = 18'(x2_reg);
            end
            OP_T2: begin
                mul_a = 33'(x2_reg);
                mul_b = 18'(SIN_B - t_reg);
            end
            OP_S: begin
                mul_a = 33'(x_reg);
                mul_b = 18'(SIN_A - t_reg);
            end
            OP_PS: begin
                mul_a = 33'(uq_reg);
                mul_b = 18'(s_reg);
            end
            OP_PC: begin
                mul_a = 33'(uq_reg);
                mul_b = 18'(c_reg);
            end
            OP_KC: begin
                mul_a = pc_reg;
                mul_b = 18'(HALF_SQRT3_Q16);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 51'(mul_a) * 51'(mul_b);

    // electrical angle from the low bits of the product
    assign prod14 = mul_p[13:0];
    assign dir14  = cfg.reverse_direction ? (14'd0 - prod14) : prod14;

    // truncate toward zero on the divide by 2^16
    assign p_adj  = mul_p[32:0] + (mul_p[32] ? 33'sd65535 : 33'sd0);

    assign s_mag  = mul_p[31:15];
    assign s_val  = quad[1] ? -signed'(s_mag) : signed'(s_mag);

    // phase voltages in Q31 millivolts, offset by half the supply
    assign half_w = signed'({4'd0, cfg.supply_mv, 30'd0});
    assign ps_w   = 50'(ps_reg);
    assign lim_w  = {cfg.voltage_limit_mv, 31'd0};
    assign dsup_w = {cfg.supply_mv, 31'd0};
    assign u_w[0] = half_w - (ps_w <<< 16);
    assign u_w[1] = half_w + (ps_w <<< 15) + kc_reg;
    assign u_w[2] = half_w + (ps_w <<< 15) - kc_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (u_w[i][49]) begin
                v_w[i] = '0;
            end else if (u_w[i] > signed'({3'd0, lim_w})) begin
                v_w[i] = lim_w;
            end else begin
                v_w[i] = u_w[i][46:0];
            end
            // times 1999 = 2048 - 32 - 16 - 1
            numer_w[i] = {v_reg[i], 11'd0} - 58'({v_reg[i], 5'd0})
                       - 58'({v_reg[i], 4'd0}) - 58'(v_reg[i]);
            if (cfg.supply_mv == 16'd0) begin
                cmp_w[i] = nz_reg[i] ? PWM_TOP : '0;
            end else if (sat_reg[i]) begin
                cmp_w[i] = PWM_TOP;
            end else begin
                cmp_w[i] = q_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mech_reg <= '0;
        end else if (cmd.capture) begin
            mech_reg <= sensor_word[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            speed_reg <= sensor_word[ANGLE_W-1:0] - mech_reg;
            tq_reg    <= torque_command;
        end
        case (cmd.op)
            OP_ELEC: elec_reg <= dir14 - cfg.zero_offset;
            OP_UQ:   uq_reg   <= cfg.run_mode ? p_adj[31:16] : 16'sd0;
            OP_X2: begin
                x_reg  <= x_cur;
                x2_reg <= mul_p[30:15];
            end
            OP_T1:   t_reg <= mul_p[30:15];
            OP_T2:   t_reg <= mul_p[30:15];
            OP_S: begin
                if (cmd.cos_sel) begin
                    c_reg <= s_val;
                end else begin
                    s_reg <= s_val;
                end
            end
            OP_PS:   ps_reg <= mul_p[32:0];
            OP_PC:   pc_reg <= mul_p[32:0];
            OP_KC:   kc_reg <= mul_p[49:0];
            OP_PHASE: begin
                for (int i = 0; i < 3; i++) begin
                    v_reg[i] <= v_w[i];
                end
            end
            OP_NUMER: begin
                for (int i = 0; i < 3; i++) begin
                    rem_reg[i] <= numer_w[i];
                    q_reg[i]   <= '0;
                    sat_reg[i] <= v_reg[i] >= dsup_w;
                    nz_reg[i]  <= v_reg[i] != '0;
                end
                d_reg <= {1'b0, dsup_w, 10'd0};
            end
            OP_DIV: begin
                // restoring division, one quotient bit per lane
                for (int i = 0; i < 3; i++) begin
                    if (rem_reg[i] >= d_reg) begin
                        rem_reg[i] <= rem_reg[i] - d_reg;
                        q_reg[i]   <= {q_reg[i][9:0], 1'b1};
                    end else begin
                        q_reg[i] <= {q_reg[i][9:0], 1'b0};
                    end
                end
                d_reg <= d_reg >> 1;
            end
            default: ;
        endcase
        if (cmd.load_out) begin
            for (int i = 0; i < 3; i++) begin
                cmp_out_reg[i] <= cmp_w[i];
            end
            mech_out_reg  <= mech_reg;
            speed_out_reg <= speed_reg;
            elec_out_reg  <= elec_reg;
        end
    end

    assign compare_a  = cmp_out_reg[0];
    assign compare_b  = cmp_out_reg[1];
    assign compare_c  = cmp_out_reg[2];
    assign mech_angle = mech_out_reg;
    assign speed      = speed_out_reg;
    assign elec_angle = elec_out_reg;

endmodule

// File: tb/sv/tb_foc_torque_modulator.sv
// Self-checking testbench of the sinusoidal torque modulator.
// Drives angle/torque transfers and APB register writes; needs ftm_pkg and the top level.
`timescale 1ns / 100ps

class ftm_scoreboard;
    logic [79:0] pending_q[$];
    int          errors;

    // register copy and sensor history
    bit          run_mode;
    bit   [5:0]  pole_pairs;
    bit          reverse_dir;
    bit   [13:0] zero_ofs;
    bit   [15:0] vlimit;
    bit   [15:0] supply;
    bit   [13:0] prev_angle;

    function void reset_state();
        run_mode = 0; pole_pairs = 7; reverse_dir = 0; zero_ofs = 0;
        vlimit = 5000; supply = 12000; prev_angle = 0; errors = 0;
    endfunction

    function longint sine_q15(bit [9:0] idx);
        bit [1:0] quad;
        longint   x, x2, t, s;
        quad = idx[9:8];
        x = longint'(idx[7:0]) << 7;
        if (quad[0]) x = 32768 - x;
        x2 = (x * x) >> 15;
        t = (2320 * x2) >> 15;
        t = (x2 * (21024 - t)) >> 15;
        s = (x * (51472 - t)) >> 15;
        return quad[1] ? -s : s;
    endfunction

    function bit [10:0] duty_count(longint u);
        longint lim, v, q;
        lim = longint'(vlimit) << 31;
        v = (u < 0) ? 0 : u;
        if (v > lim) v = lim;
        if (supply == 0) q = (v > 0) ? 1999 : 0;
        else q = longint'((128'(v) * 1999) / (128'(supply) << 31));
        if (q > 1999) q = 1999;
        return q[10:0];
    endfunction

    // note an accepted input transfer and queue its expected result
    function void note_tick(logic [31:0] data);
        bit [13:0] mech, diff, elec, prod;
        bit [9:0]  idx;
        longint    tq, p, uq, s, c, st, ksb, h31;
        mech = data[13:0];
        diff = mech - prev_angle;
        prev_angle = mech;
        prod = mech * pole_pairs;
        if (reverse_dir) prod = 14'd0 - prod;
        elec = prod - zero_ofs;
        tq = longint'($signed(data[31:16]));
        p = tq * vlimit;
        uq = (p >= 0) ? (p >>> 16) : -((-p) >>> 16);
        if (!run_mode) uq = 0;
        idx = elec[13:4];
        s = sine_q15(idx);
        c = sine_q15(idx + 10'd256);
        st = uq * s * 32768;
        ksb = uq * c * 56756;
        h31 = longint'(supply) * 1073741824;
        pending_q.push_back({5'd0, elec, diff, mech, duty_count(st - ksb + h31),
                             duty_count(st + ksb + h31), duty_count(-2 * st + h31)});
    endfunction

    function void check_result(logic [79:0] got);
        logic [79:0] exp_v;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        exp_v = pending_q.pop_front();
        if (got[10:0] !== exp_v[10:0])
            $display("%0t: compare_a exp %0d got %0d", $time, exp_v[10:0], got[10:0]);
        if (got[21:11] !== exp_v[21:11])
            $display("%0t: compare_b exp %0d got %0d", $time, exp_v[21:11], got[21:11]);
        if (got[32:22] !== exp_v[32:22])
            $display("%0t: compare_c exp %0d got %0d", $time, exp_v[32:22], got[32:22]);
        if (got[46:33] !== exp_v[46:33])
            $display("%0t: mech_angle exp %0d got %0d", $time, exp_v[46:33], got[46:33]);
        if (got[60:47] !== exp_v[60:47])
            $display("%0t: speed exp %0d got %0d", $time, exp_v[60:47], got[60:47]);
        if (got[74:61] !== exp_v[74:61])
            $display("%0t: elec_angle exp %0d got %0d", $time, exp_v[74:61], got[74:61]);
        if (got[74:0] !== exp_v[74:0]) errors++;
    endfunction
endclass

module tb_foc_torque_modulator;
    import ftm_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = 0;      // sensor_word[15:0], torque_command[31:16]
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [79:0] m_tdata;          // compare_a, compare_b, compare_c, mech, speed, elec
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    ftm_scoreboard sb;
    bit          calm;             // no idling in the closing stretch
    int          idle_cycles = 0;
    int          stall_left = 0;
    bit          timed_out;

    foc_torque_modulator i_dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // write one register: setup cycle, then access cycle; mirror it in the model
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_W'(idx) << 2; pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_RUN_MODE: sb.run_mode    = val[0];
            REG_POLE:     sb.pole_pairs  = val[5:0];
            REG_REVERSE:  sb.reverse_dir = val[0];
            REG_ZERO_OFS: sb.zero_ofs    = val[13:0];
            REG_VLIMIT:   sb.vlimit      = val[15:0];
            REG_SUPPLY:   sb.supply      = val[15:0];
            default: ;
        endcase
    endtask

    // present one tick and hold it until the transfer
    task automatic send_tick(logic [15:0] sensor, logic [15:0] torque);
        if (!calm && $urandom_range(3) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {torque, sensor};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_tick({torque, sensor});
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic random_phase(int n);
        logic [13:0] ang;
        ang = 14'($urandom);
        repeat (n) begin
            // mostly smooth rotation, sometimes arbitrary jumps
            if ($urandom_range(4) == 0) ang = 14'($urandom);
            else ang = ang + 14'($urandom_range(0, 400)) - 14'd200;
            send_tick({2'($urandom), ang}, 16'($urandom));
        end
    endtask

    // sample results and drive ready with random stall bursts
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (calm) begin
                m_tready   <= 1;
                stall_left <= 0;
            end else if (stall_left > 0) begin
                m_tready   <= 0;
                stall_left <= stall_left - 1;
            end else if ($urandom_range(3) == 0) begin
                m_tready   <= 0;
                stall_left <= $urandom_range(0, 5);
            end else begin
                m_tready <= 1;
            end
        end
    end

    // watchdog: count cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("foc_torque_modulator regression: fail");
            $finish;
        end
    end

    initial begin
        sb = new();
        sb.reset_state();
        calm = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;

        // directed: stop mode first, with half-turn speed and first-tick cases
        send_tick(16'h0000, 16'h7fff);
        send_tick(16'h2000, 16'h8000);
        send_tick(16'hffff, 16'h0000);
        drain();
        reg_write(REG_RUN_MODE, 1);
        send_tick(16'h0000, 16'h7fff);
        send_tick(16'h1000, 16'h8000);
        send_tick(16'hc3ff, 16'h4000);
        send_tick(16'h3fff, 16'hc000);
        drain();
        reg_write(REG_POLE, 32);
        reg_write(REG_REVERSE, 1);
        reg_write(REG_ZERO_OFS, 16383);
        reg_write(REG_VLIMIT, 48000);
        reg_write(REG_SUPPLY, 48000);
        send_tick(16'h1234, 16'h7fff);
        send_tick(16'h0aaa, 16'h8000);
        drain();
        reg_write(REG_POLE, 0);
        reg_write(REG_VLIMIT, 0);
        reg_write(REG_SUPPLY, 1000);
        send_tick(16'h2555, 16'h7fff);
        drain();
        reg_write(REG_SUPPLY, 0);
        reg_write(REG_VLIMIT, 30000);
        reg_write(REG_POLE, 1);
        send_tick(16'h0100, 16'h7fff);
        send_tick(16'h0300, 16'h8000);
        drain();

        // random settings per phase
        for (int ph = 0; ph < 8; ph++) begin
            reg_write(REG_RUN_MODE, (ph == 0) ? 0 : $urandom_range(1));
            reg_write(REG_POLE, $urandom_range(63));
            reg_write(REG_REVERSE, $urandom_range(1));
            reg_write(REG_ZERO_OFS, $urandom);
            reg_write(REG_VLIMIT, (ph == 1) ? 65535 : $urandom_range(48000));
            reg_write(REG_SUPPLY, (ph == 2) ? 65535 : $urandom_range(1000, 48000));
            if (ph == 7) calm = 1;
            random_phase(60);
            drain();
        end

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("foc_torque_modulator regression: pass");
        else
            $display("foc_torque_modulator regression: fail");
        $finish;
    end
endmodule
